### src/scsa_pkg.sv
// Shared types, constants and helper functions for the slab allocator.
`timescale 1ns / 1ps
package scsa_pkg;
  localparam int PgBits      = 12;
  localparam int MinBits     = 4;
  localparam int WordBits    = 6;
  localparam int WordsPerFrm = 4;
  localparam int DefFrames   = 64;
  localparam int AddrW       = 18;
  localparam int SizeW       = 32;
  localparam int UsizeW      = 12;
  localparam int ClsW        = 3;
  localparam int MaxSmall    = 2048;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_NO_FRAME = 3'd3,
    ST_NOT_FND  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FSCAN,
    S_FRD,
    S_WSCAN,
    S_CLAIM,
    S_FREE_RD,
    S_FREE_WR,
    S_ECHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] address;
    logic             null_pointer;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [AddrW-1:0]  slot_address;
    logic [UsizeW-1:0] class_bytes;
    logic              frame_released;
  } out_item_t;

  // Mask of the bits of word w that hold real slots for class cls.
  function automatic logic [63:0] valid_mask(input logic [ClsW-1:0] cls,
                                             input logic [1:0] w);
    logic [8:0] n;
    logic [8:0] lo;
    logic [8:0] d;
    n  = 9'd256 >> cls;
    lo = {1'b0, w, 6'd0};
    if (n >= lo + 9'd64) begin
      return '1;
    end else if (n <= lo) begin
      return '0;
    end else begin
      d = n - lo;
      return (64'd1 << d[5:0]) - 64'd1;
    end
  endfunction

  // Index of the lowest set bit; 63 when none is set.
  function automatic logic [5:0] low_bit(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction
endpackage

### src/scsa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module scsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/size_class_slab_allocator_top.sv
// Top level of the power-of-two size-class slab allocator.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item_t  (kind, size, address, null)
//  out_    | output    | out_valid/out_stall| out_item_t (status, slot, size, released)
//
// One item at a time: the input stalls until the previous result has
// transferred. An error goes from S_FSCAN straight to S_OUT, a query reads the
// frame class in S_FREE_RD, and a free reads, writes back and runs a four-word
// empty check with the written word forwarded. Allocate walks the frame table
// one frame per cycle, plus 1 to 4 bitmap word reads for each in-use frame; on a
// miss it scans again from frame 0 for the lowest free frame and clears its four words.
// The frame-class table and bitmaps live in RAMs with registered read data; the
// in-use bits are flip-flops cleared at reset. No clearing pass is needed.
// A finished result waits in the output register while out_stall is high.
`timescale 1ns / 1ps
module size_class_slab_allocator_top
  import scsa_pkg::*;
#(
  parameter int FRAMES = DefFrames
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int BW = FW + 2;

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [ClsW-1:0] cls_r, cls_nxt;
  logic [FW:0] fidx_r, fidx_nxt;
  logic [1:0] widx_r, widx_nxt;
  logic [FRAMES-1:0] in_use_r;
  logic out_valid_r;
  out_item_t out_r;
  logic [63:0] word_r;
  logic any_r;

  logic cls_we;
  logic [FW-1:0] cls_waddr, cls_raddr;
  logic [ClsW-1:0] cls_wdata, cls_rdata;
  logic bm_we;
  logic [BW-1:0] bm_waddr, bm_raddr;
  logic [63:0] bm_wdata, bm_rdata;

  scsa_ram #(.Width(ClsW), .Depth(FRAMES)) u_cls (
    .clk, .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
    .raddr(cls_raddr), .rdata(cls_rdata));
  scsa_ram #(.Width(64), .Depth(FRAMES * WordsPerFrm)) u_bm (
    .clk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata));

  // Request decode.
  logic [FW-1:0] fcur;
  logic [AddrW-PgBits-1:0] afrm;
  logic [FW-1:0] afrm_idx;
  logic [PgBits-1:0] aoff;
  logic [3:0] cls_sh;
  logic [3:0] rd_sh;
  logic [UsizeW-1:0] cls_size;
  logic [7:0] aslot;
  logic [63:0] open_w;
  logic [63:0] chk_w;
  logic [7:0] found_slot;
  logic [ClsW-1:0] req_cls;
  logic [FRAMES-1:0] free_vec;
  logic afrm_ok;
  logic claim_go;
  status_t fscan_st;
  assign fcur  = fidx_r[FW-1:0];
  assign afrm  = req_r.address[AddrW-1:PgBits];
  assign afrm_idx = FW'(afrm);
  assign aoff  = req_r.address[PgBits-1:0];
  // Shift amounts span 4..11, so carry them in four bits.
  assign cls_sh = 4'(cls_r) + 4'(MinBits);
  assign rd_sh  = 4'(cls_rdata) + 4'(MinBits);
  assign cls_size = UsizeW'(16'd1 << cls_sh);
  assign aslot = 8'(aoff >> cls_sh);
  assign open_w = ~bm_rdata & valid_mask(cls_r, widx_r);
  assign found_slot = {widx_r, low_bit(open_w)};
  assign afrm_ok = (32'(afrm) < 32'(FRAMES));
  // The word written back on a free is read in the same cycle; take it from word_r.
  assign chk_w = (widx_r == aslot[7:6]) ? word_r : bm_rdata;

  always_comb begin
    req_cls = 3'd7;
    for (int c = 6; c >= 0; c--) begin
      if (req_r.request_size <= (SizeW'(1) << (c + MinBits))) req_cls = 3'(c);
    end
  end

  always_comb begin
    fscan_st = ST_OK;
    if (req_r.kind == KIND_ALLOC) begin
      if (req_r.request_size == '0) fscan_st = ST_NULL;
      else if (req_r.request_size > SizeW'(MaxSmall)) fscan_st = ST_TOO_BIG;
    end else if (req_r.kind != KIND_NONE) begin
      if (req_r.null_pointer) fscan_st = ST_NULL;
      else if (!afrm_ok || !in_use_r[afrm_idx]) fscan_st = ST_NOT_FND;
    end
  end

  // Lowest free frame: scanned one frame per cycle in S_CLAIM via fidx_r.
  assign free_vec = ~in_use_r;
  // Once a free frame is found, stay on it while its four words are cleared.
  assign claim_go = (fidx_r != (FW+1)'(FRAMES)) && (free_vec[fcur] || widx_r != 2'd0);

  logic [AddrW-1:0] slot_addr;
  assign slot_addr = AddrW'((32'(fcur) << PgBits) + (32'(found_slot) << cls_sh));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid && !in_stall) state_nxt = S_FSCAN;
      S_FSCAN: begin
        case (kind_t'(req_r.kind))
          KIND_ALLOC: begin
            if (req_r.request_size == '0 ||
                req_r.request_size > SizeW'(MaxSmall)) state_nxt = S_OUT;
            else state_nxt = S_FRD;
          end
          KIND_FREE, KIND_QUERY: begin
            if (req_r.null_pointer || !afrm_ok || !in_use_r[afrm_idx])
              state_nxt = S_OUT;
            else state_nxt = S_FREE_RD;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_FRD: begin
        if (fidx_r == (FW+1)'(FRAMES)) state_nxt = S_CLAIM;
        else if (in_use_r[fcur]) state_nxt = S_WSCAN;
      end
      S_WSCAN: begin
        if (cls_rdata != cls_r) state_nxt = S_FRD;
        else if (open_w != '0) state_nxt = S_OUT;
        else if (widx_r == 2'd3) state_nxt = S_FRD;
      end
      S_CLAIM: begin
        if (fidx_r == (FW+1)'(FRAMES) || (claim_go && widx_r == 2'd3)) state_nxt = S_OUT;
      end
      S_FREE_RD: begin
        if (req_r.kind == KIND_QUERY) state_nxt = S_OUT;
        else state_nxt = S_FREE_WR;
      end
      S_FREE_WR: state_nxt = S_ECHK;
      S_ECHK:    if (widx_r == 2'd3) state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    fidx_nxt  = fidx_r;
    widx_nxt  = widx_r;
    cls_nxt   = cls_r;
    cls_we    = 1'b0;
    cls_waddr = fcur;
    cls_wdata = cls_r;
    cls_raddr = fcur;
    bm_we     = 1'b0;
    bm_waddr  = {fcur, widx_r};
    bm_wdata  = bm_rdata;
    bm_raddr  = {fcur, widx_r};
    case (state_r)
      S_FSCAN: begin
        fidx_nxt  = '0;
        widx_nxt  = '0;
        cls_nxt   = req_cls;
        cls_raddr = afrm_idx;
        if (req_r.kind != KIND_ALLOC) fidx_nxt = (FW+1)'(afrm_idx);
      end
      S_FRD: begin
        widx_nxt = '0;
        if (fidx_r == (FW+1)'(FRAMES)) fidx_nxt = '0;
        else if (!in_use_r[fcur]) fidx_nxt = fidx_r + 1'b1;
        bm_raddr = {fcur, 2'd0};
      end
      S_WSCAN: begin
        bm_raddr = {fcur, widx_r + 2'd1};
        if (cls_rdata != cls_r) begin
          fidx_nxt = fidx_r + 1'b1;
        end else if (open_w != '0) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | (64'd1 << found_slot[5:0]);
        end else if (widx_r == 2'd3) begin
          fidx_nxt = fidx_r + 1'b1;
        end else begin
          widx_nxt = widx_r + 2'd1;
        end
      end
      S_CLAIM: begin
        if (claim_go) begin
          // Write the class once, then clear all four words with slot 0 taken.
          cls_we   = (widx_r == 2'd0);
          bm_we    = 1'b1;
          bm_waddr = {fcur, widx_r};
          bm_wdata = (widx_r == 2'd0) ? 64'd1 : 64'd0;
          widx_nxt = widx_r + 2'd1;
        end else if (fidx_r != (FW+1)'(FRAMES)) begin
          fidx_nxt = fidx_r + 1'b1;
        end
      end
      S_FREE_RD: begin
        cls_nxt  = cls_rdata;
        widx_nxt = 2'(8'(aoff >> rd_sh) >> WordBits);
        bm_raddr = {fcur, widx_nxt};
      end
      S_FREE_WR: begin
        bm_we    = 1'b1;
        bm_waddr = {fcur, aslot[7:6]};
        bm_wdata = bm_rdata & ~(64'd1 << aslot[5:0]);
        widx_nxt = '0;
        bm_raddr = {fcur, 2'd0};
      end
      S_ECHK: begin
        widx_nxt = widx_r + 2'd1;
        bm_raddr = {fcur, widx_r + 2'd1};
      end
      default: ;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      fidx_r      <= '0;
      widx_r      <= '0;
      cls_r       <= '0;
      any_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fidx_r  <= fidx_nxt;
      widx_r  <= widx_nxt;
      cls_r   <= cls_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !in_stall) req_r <= in_data;
        S_FSCAN: begin
          out_r <= {fscan_st, AddrW'(0), UsizeW'(0), 1'b0};
          any_r <= 1'b0;
        end
        S_WSCAN: if (cls_rdata == cls_r && open_w != '0) begin
          out_r <= {ST_OK, slot_addr, cls_size, 1'b0};
        end
        S_CLAIM: begin
          if (fidx_r == (FW+1)'(FRAMES)) begin
            out_r <= {ST_NO_FRAME, AddrW'(0), UsizeW'(0), 1'b0};
          end else if (free_vec[fcur] && widx_r == 2'd0) begin
            in_use_r[fcur] <= 1'b1;
            out_r <= {ST_OK, AddrW'(32'(fcur) << PgBits), cls_size, 1'b0};
          end
        end
        S_FREE_RD: if (req_r.kind == KIND_QUERY)
          out_r.class_bytes <= UsizeW'(16'd1 << rd_sh);
        S_FREE_WR: word_r <= bm_wdata;
        S_ECHK: begin
          if ((chk_w & valid_mask(cls_r, widx_r)) != '0) any_r <= 1'b1;
          if (widx_r == 2'd3 &&
              !(any_r || (chk_w & valid_mask(cls_r, widx_r)) != '0)) begin
            in_use_r[fcur]       <= 1'b0;
            out_r.frame_released <= 1'b1;
          end
        end
        S_OUT: if (!out_valid_r) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Hold input until the current transfer has fully left the output register.
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.slot_address == '0)
    else $error("error result carries an address");
  a_rel_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_released |-> out_data.status == ST_OK)
    else $error("release flagged on failed request");
endmodule
